// File: sv/matinv_pkg.sv
// Shared constants, cofactor index table and sideband types for the 3x3 inverse.
package matinv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_ENT = 9;
  localparam int NUM_COL = 3;

  // Adjugate entry k is ent[p]*ent[q] - ent[r]*ent[s], entries indexed row*3+col.
  localparam logic [3:0] ADJ_TAB [NUM_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Adjugate entries that multiply the first row in the determinant expansion.
  localparam logic [3:0] DET_ADJ [NUM_COL] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic singular;
    logic det_neg;
  } matinv_flags_t;

endpackage

// File: sv/matinv_cofactor.sv
// Products of entry pairs and the nine adjugate differences, two pipeline stages.
module matinv_cofactor import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [DATA_WIDTH-1:0]  ent [NUM_ENT],
  output logic signed [2*DATA_WIDTH:0]  adj [NUM_ENT],
  output logic signed [DATA_WIDTH-1:0]  row0 [NUM_COL]
);

  localparam int PW = 2 * DATA_WIDTH;

  logic signed [PW-1:0]         prod_p [NUM_ENT];
  logic signed [PW-1:0]         prod_q [NUM_ENT];
  logic signed [DATA_WIDTH-1:0] row0_s1 [NUM_COL];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        prod_p[k] <= ent[ADJ_TAB[k][0]] * ent[ADJ_TAB[k][1]];
        prod_q[k] <= ent[ADJ_TAB[k][2]] * ent[ADJ_TAB[k][3]];
      end
      for (int j = 0; j < NUM_COL; j++) begin
        row0_s1[j] <= ent[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        adj[k] <= $signed({prod_p[k][PW-1], prod_p[k]}) - $signed({prod_q[k][PW-1], prod_q[k]});
      end
      for (int j = 0; j < NUM_COL; j++) begin
        row0[j] <= row0_s1[j];
      end
    end
  end

endmodule

// File: sv/matinv_det.sv
// Determinant by split partial products, then magnitudes and signs of all values.
module matinv_det import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [3:0]                    en,
  input  logic signed [2*DATA_WIDTH:0]  adj [NUM_ENT],
  input  logic signed [DATA_WIDTH-1:0]  row0 [NUM_COL],
  output logic [2*DATA_WIDTH-1:0]       adjm [NUM_ENT],
  output logic [NUM_ENT-1:0]            adj_neg,
  output logic [3*DATA_WIDTH+2:0]       detm,
  output matinv_flags_t                 flags
);

  localparam int W   = DATA_WIDTH;
  localparam int AW  = 2 * W + 1;
  localparam int DTW = 3 * W + 4;

  logic signed [AW-1:0]  lo [NUM_COL];
  logic signed [AW-1:0]  hi [NUM_COL];
  logic signed [AW-1:0]  adj3 [NUM_ENT];
  logic signed [AW-1:0]  adj4 [NUM_ENT];
  logic signed [AW-1:0]  adj5 [NUM_ENT];
  logic signed [DTW-1:0] term [NUM_COL];
  logic signed [DTW-1:0] det;
  logic signed [DTW-1:0] det_abs;
  logic signed [AW-1:0]  adj_abs [NUM_ENT];

  // The wide adjugate factor is split at W bits: an unsigned low half and a signed high half.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < NUM_COL; j++) begin
        lo[j] <= row0[j] * $signed({1'b0, adj[DET_ADJ[j]][W-1:0]});
        hi[j] <= row0[j] * $signed(adj[DET_ADJ[j]][AW-1:W]);
      end
      adj3 <= adj;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < NUM_COL; j++) begin
        term[j] <= (DTW'(hi[j]) <<< W) + DTW'(lo[j]);
      end
      adj4 <= adj3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det  <= term[0] + term[1] + term[2];
      adj5 <= adj4;
    end
  end

  always_comb begin
    det_abs = det[DTW-1] ? -det : det;
    for (int k = 0; k < NUM_ENT; k++) begin
      adj_abs[k] = adj5[k][AW-1] ? -adj5[k] : adj5[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      detm           <= det_abs[DTW-2:0];
      flags.det_neg  <= det[DTW-1];
      flags.singular <= (det == '0);
      for (int k = 0; k < NUM_ENT; k++) begin
        adjm[k]    <= adj_abs[k][AW-2:0];
        adj_neg[k] <= adj5[k][AW-1];
      end
    end
  end

endmodule

// File: sv/matinv_div_lane.sv
// One divider lane: rounded quotient of an adjugate magnitude by the determinant, one bit a stage.
module matinv_div_lane import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic [DATA_WIDTH:0]        en,
  input  logic [2*DATA_WIDTH-1:0]    adjm,
  input  logic [3*DATA_WIDTH+2:0]    detm,
  output logic [DATA_WIDTH-1:0]      quo,
  output logic                       sat
);

  localparam int W    = DATA_WIDTH;
  localparam int AMW  = 2 * W;
  localparam int DMW  = 3 * W + 3;
  localparam int DVW  = DMW + 1;
  localparam int NA   = AMW + 2 * FRAC_BITS + 1;
  localparam int NW   = ((NA > DMW) ? NA : DMW) + 1;
  localparam int CW   = (NW > DVW + W) ? NW : DVW + W;

  logic [NW-1:0]  num;
  logic [DVW-1:0] d2;
  logic [CW-1:0]  num_c;
  logic [CW-1:0]  lim_c;

  logic [DVW-1:0] rem   [W+1];
  logic [DVW-1:0] dsr   [W+1];
  logic [W-1:0]   nlo   [W+1];
  logic [W-1:0]   quo_s [W+1];
  logic           sat_s [W+1];

  // Rounding to nearest is folded in: (2*adj*2^(2F) + det) / (2*det).
  always_comb begin
    num   = (NW'(adjm) << (2 * FRAC_BITS + 1)) + NW'(detm);
    d2    = {detm, 1'b0};
    num_c = CW'(num);
    lim_c = CW'(d2) << W;
  end

  // A quotient of 2^W or more is beyond any code, so only W quotient bits are developed.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sat_s[0] <= (num_c >= lim_c);
      rem[0]   <= DVW'(num_c >> W);
      nlo[0]   <= num[W-1:0];
      dsr[0]   <= d2;
      quo_s[0] <= '0;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    logic [DVW:0] part;
    logic [DVW:0] diff;
    logic         ge;

    always_comb begin
      part = {rem[s-1], nlo[s-1][W-1]};
      diff = part - {1'b0, dsr[s-1]};
      ge   = (part >= {1'b0, dsr[s-1]});
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s]   <= ge ? diff[DVW-1:0] : part[DVW-1:0];
        nlo[s]   <= nlo[s-1] << 1;
        dsr[s]   <= dsr[s-1];
        quo_s[s] <= {quo_s[s-1][W-2:0], ge};
        sat_s[s] <= sat_s[s-1];
      end
    end
  end

  assign quo = quo_s[W];
  assign sat = sat_s[W];

endmodule

// File: sv/matinv_merge.sv
// Output register: signs, saturation, singular override and the overflow flag over all lanes and the determinant.
module matinv_merge import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [DATA_WIDTH-1:0]         quo [NUM_ENT],
  input  logic [NUM_ENT-1:0]            sat,
  input  logic [NUM_ENT-1:0]            adj_neg,
  input  matinv_flags_t                 flags,
  input  logic [3*DATA_WIDTH+3:0]       drm,
  output logic signed [DATA_WIDTH-1:0]  inv [NUM_ENT],
  output logic signed [DATA_WIDTH-1:0]  det,
  output logic                          singular,
  output logic                          overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int MW = 3 * W + 4;

  logic [W:0]    inv_code [NUM_ENT];
  logic [W:0]    det_code;
  logic          ovf_any;
  logic [MW-1:0] lane_mag;
  logic          lane_neg;

  // Returns {saturated, code} for a sign and magnitude.
  function automatic logic [W:0] sat_code(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  code;
    logic          hit;
    lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    hit = (m > lim);
    if (hit) begin
      code = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      code = neg ? -m[W-1:0] : m[W-1:0];
    end
    return {hit, code};
  endfunction

  always_comb begin
    ovf_any  = 1'b0;
    lane_mag = '0;
    lane_neg = 1'b0;
    for (int k = 0; k < NUM_ENT; k++) begin
      lane_mag    = sat[k] ? '1 : MW'(quo[k]);
      lane_neg    = (lane_mag != '0) && (adj_neg[k] != flags.det_neg);
      inv_code[k] = sat_code(lane_neg, lane_mag);
      ovf_any     = ovf_any | inv_code[k][W];
    end
    det_code = sat_code((drm != '0) && flags.det_neg, drm);
    ovf_any  = ovf_any | det_code[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        inv[k] <= flags.singular ? '0 : inv_code[k][W-1:0];
      end
      det      <= flags.singular ? '0 : det_code[W-1:0];
      singular <= flags.singular;
      overflow <= !flags.singular && ovf_any;
    end
  end

endmodule

// File: sv/matrix3x3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
//   channel   handshake              payload
//   matrix    mat_valid / mat_stall  a00 .. a22
//   result    res_valid / res_stall  inv00 .. inv22, determinant, singular, overflow
//
// One request is taken every cycle while mat_stall is low, and the divider lanes develop
// one quotient bit per stage.
// Every pipeline stage has its own valid bit, so bubbles close up behind a stalled result
// and mat_stall rises only when every stage holds a request.
// Reset is synchronous and clears only the valid bits.
module matrix3x3_inverse import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mat_valid,
  output logic                          mat_stall,
  input  logic signed [DATA_WIDTH-1:0]  a00,
  input  logic signed [DATA_WIDTH-1:0]  a01,
  input  logic signed [DATA_WIDTH-1:0]  a02,
  input  logic signed [DATA_WIDTH-1:0]  a10,
  input  logic signed [DATA_WIDTH-1:0]  a11,
  input  logic signed [DATA_WIDTH-1:0]  a12,
  input  logic signed [DATA_WIDTH-1:0]  a20,
  input  logic signed [DATA_WIDTH-1:0]  a21,
  input  logic signed [DATA_WIDTH-1:0]  a22,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [DATA_WIDTH-1:0]  inv00,
  output logic signed [DATA_WIDTH-1:0]  inv01,
  output logic signed [DATA_WIDTH-1:0]  inv02,
  output logic signed [DATA_WIDTH-1:0]  inv10,
  output logic signed [DATA_WIDTH-1:0]  inv11,
  output logic signed [DATA_WIDTH-1:0]  inv12,
  output logic signed [DATA_WIDTH-1:0]  inv20,
  output logic signed [DATA_WIDTH-1:0]  inv21,
  output logic signed [DATA_WIDTH-1:0]  inv22,
  output logic signed [DATA_WIDTH-1:0]  determinant,
  output logic                          singular,
  output logic                          overflow
);

  localparam int W   = DATA_WIDTH;
  localparam int DMW = 3 * W + 3;
  localparam int NS  = W + 8;
  localparam int LB  = 6;

  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS-1:0] en;

  logic signed [W-1:0]   ent [NUM_ENT];
  logic signed [2*W:0]   adj [NUM_ENT];
  logic signed [W-1:0]   row0 [NUM_COL];
  logic [2*W-1:0]        adjm [NUM_ENT];
  logic [NUM_ENT-1:0]    adj_neg;
  logic [DMW-1:0]        detm;
  matinv_flags_t         flags;
  logic [W-1:0]          quo [NUM_ENT];
  logic [NUM_ENT-1:0]    sat;
  logic signed [W-1:0]   inv [NUM_ENT];

  logic [DMW:0]          half;
  logic [DMW:0]          drm0;
  matinv_flags_t         side_flags [W+1];
  logic [NUM_ENT-1:0]    side_neg   [W+1];
  logic [DMW:0]          side_drm   [W+1];

  // A stage may load when it or any stage after it holds a bubble, or the output moves.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en[i] = !res_stall || (((~vld) >> i) != '0);
    end
    vld_next = ({vld[NS-2:0], mat_valid} & en) | (vld & ~en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign mat_stall = !en[0];
  assign res_valid = vld[NS-1];

  assign ent = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  matinv_cofactor #(.DATA_WIDTH(W)) u_cofactor (
    .clk  (clk),
    .en   (en[1:0]),
    .ent  (ent),
    .adj  (adj),
    .row0 (row0)
  );

  matinv_det #(.DATA_WIDTH(W)) u_det (
    .clk     (clk),
    .en      (en[5:2]),
    .adj     (adj),
    .row0    (row0),
    .adjm    (adjm),
    .adj_neg (adj_neg),
    .detm    (detm),
    .flags   (flags)
  );

  for (genvar k = 0; k < NUM_ENT; k++) begin : g_lane
    matinv_div_lane #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (en[LB+W:LB]),
      .adjm (adjm[k]),
      .detm (detm),
      .quo  (quo[k]),
      .sat  (sat[k])
    );
  end

  // Determinant rounding and the sideband ride alongside the divider lanes.
  always_comb begin
    half = ({{DMW{1'b0}}, 1'b1} << (2 * FRAC_BITS)) >> 1;
    drm0 = ({1'b0, detm} + half) >> (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[LB]) begin
      side_flags[0] <= flags;
      side_neg[0]   <= adj_neg;
      side_drm[0]   <= drm0;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[LB+s]) begin
        side_flags[s] <= side_flags[s-1];
        side_neg[s]   <= side_neg[s-1];
        side_drm[s]   <= side_drm[s-1];
      end
    end
  end

  matinv_merge #(.DATA_WIDTH(W)) u_merge (
    .clk      (clk),
    .en       (en[NS-1]),
    .quo      (quo),
    .sat      (sat),
    .adj_neg  (side_neg[W]),
    .flags    (side_flags[W]),
    .drm      (side_drm[W]),
    .inv      (inv),
    .det      (determinant),
    .singular (singular),
    .overflow (overflow)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

endmodule

// File: sv/matinv_checker.sv
// Port-level checks for the 3x3 inverse and the bind that attaches them.
module matinv_checker import matinv_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         mat_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic signed [DATA_WIDTH-1:0] inv00,
  input logic signed [DATA_WIDTH-1:0] inv01,
  input logic signed [DATA_WIDTH-1:0] inv02,
  input logic signed [DATA_WIDTH-1:0] inv10,
  input logic signed [DATA_WIDTH-1:0] inv11,
  input logic signed [DATA_WIDTH-1:0] inv12,
  input logic signed [DATA_WIDTH-1:0] inv20,
  input logic signed [DATA_WIDTH-1:0] inv21,
  input logic signed [DATA_WIDTH-1:0] inv22,
  input logic signed [DATA_WIDTH-1:0] determinant,
  input logic                         singular,
  input logic                         overflow
);

  // A singular matrix reports an all-zero result with no overflow.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && singular |-> determinant == '0 && !overflow &&
      inv00 == '0 && inv01 == '0 && inv02 == '0 && inv10 == '0 && inv11 == '0 &&
      inv12 == '0 && inv20 == '0 && inv21 == '0 && inv22 == '0)
    else $error("singular result carries nonzero data or overflow");

  // Back pressure on the matrix side can only come from a stalled result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !res_stall |-> !mat_stall)
    else $error("matrix side stalled while the result side is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(determinant) && $stable(inv00) &&
      $stable(singular) && $stable(overflow))
    else $error("stalled result changed");

endmodule

bind matrix3x3_inverse matinv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_matinv_checker (.*);
